>>> hdl/rlbs_pkg.sv
// Shared types and codes for the run-list bitmap set-operation block.
package rlbs_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ORDER    = 2'd1,
    ST_FULL     = 2'd2,
    ST_BEYOND   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_UNION = 2'd0,
    OP_INTER = 2'd1,
    OP_COMPL = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_STEP,
    BK_TAIL,
    BK_FLUSH
  } back_state_e;

  localparam int unsigned CFG_BITMAP_SIZE = 0;
  localparam int unsigned CFG_SET_OP      = 1;

endpackage

>>> hdl/rlbs_front.sv
// Front end: classifies each item, checks and appends or merges load runs, queues work.
module rlbs_front #(
  parameter int unsigned MAX_RUNS  = 16,
  parameter int unsigned POS_WIDTH = 32,
  localparam int unsigned IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1,
  localparam int unsigned CW = $clog2(MAX_RUNS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           func_i,
  input  logic [POS_WIDTH-1:0] start_i,
  input  logic [POS_WIDTH-1:0] length_i,
  input  logic [31:0]          bitmap_size_i,
  input  logic                 back_busy_i,
  output logic                 busy_o,
  // last-run lookup for the merge check
  input  logic [POS_WIDTH-1:0] lr_start_i,
  input  logic [POS_WIDTH-1:0] lr_length_i,
  // list write port
  output logic                 wr_en_o,
  output logic                 wr_b_o,
  output logic [IW-1:0]        wr_idx_o,
  output logic [POS_WIDTH-1:0] wr_start_o,
  output logic [POS_WIDTH-1:0] wr_length_o,
  output logic [CW-1:0]        used_a_o,
  output logic [CW-1:0]        used_b_o,
  // queue to back end: single entry
  output logic                 q_valid_o,
  output logic                 q_compute_o,
  output logic [1:0]           q_status_o,
  input  logic                 q_take_i
);
  import rlbs_pkg::*;

  logic                 pend_q, pend_d;
  logic [1:0]           func_q;
  logic [POS_WIDTH-1:0] s_q, l_q;
  logic [CW-1:0]        used_a_q, used_a_d, used_b_q, used_b_d;
  logic                 qv_q, qv_d, qc_q, qc_d;
  logic [1:0]           qs_q, qs_d;
  logic [CW-1:0]        n;
  logic [POS_WIDTH:0]   sum, pend_e;
  logic [1:0]           st;
  logic                 merge, append, sel_b;

  // hold commands off while one is pending or queued, or while the back end walks the lists
  assign busy_o      = pend_q | qv_q | back_busy_i;
  assign sel_b       = (func_q == FUNC_LOAD_B);
  assign n           = sel_b ? used_b_q : used_a_q;
  assign sum         = {1'b0, s_q} + {1'b0, l_q};
  assign pend_e      = {1'b0, lr_start_i} + {1'b0, lr_length_i} - 1'b1;

  always_comb begin
    st     = ST_OK;
    merge  = 1'b0;
    append = 1'b0;
    if (l_q == '0) begin
      st = ST_OK;
    end else if ({{(64-POS_WIDTH-1){1'b0}}, sum} > {32'd0, bitmap_size_i}) begin
      st = ST_BEYOND;
    end else if (n != '0 && {1'b0, s_q} <= pend_e) begin
      st = ST_ORDER;
    end else if (n != '0 && {1'b0, s_q} == pend_e + 1'b1) begin
      merge = 1'b1;
    end else if (n >= CW'(MAX_RUNS)) begin
      st = ST_FULL;
    end else begin
      append = 1'b1;
    end
  end

  always_comb begin
    wr_en_o     = 1'b0;
    wr_b_o      = sel_b;
    wr_idx_o    = merge ? IW'(n - 1'b1) : IW'(n);
    wr_start_o  = merge ? lr_start_i : s_q;
    wr_length_o = merge ? lr_length_i + l_q : l_q;
    used_a_d    = used_a_q;
    used_b_d    = used_b_q;
    pend_d      = pend_q;
    qv_d        = qv_q & ~q_take_i;
    qc_d        = qc_q;
    qs_d        = qs_q;
    if (in_valid_i) begin
      pend_d = 1'b1;
    end
    if (pend_q && !qv_q) begin
      pend_d = 1'b0;
      qv_d   = 1'b1;
      qc_d   = (func_q == FUNC_COMPUTE);
      qs_d   = ST_OK;
      unique case (func_q)
        FUNC_LOAD_A, FUNC_LOAD_B: begin
          qs_d    = st;
          wr_en_o = merge | append;
          if (append) begin
            if (sel_b) used_b_d = used_b_q + 1'b1;
            else       used_a_d = used_a_q + 1'b1;
          end
        end
        FUNC_CLEAR: begin
          used_a_d = '0;
          used_b_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      qv_q     <= 1'b0;
      used_a_q <= '0;
      used_b_q <= '0;
    end else begin
      pend_q   <= pend_d;
      qv_q     <= qv_d;
      used_a_q <= used_a_d;
      used_b_q <= used_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      func_q <= func_i;
      s_q    <= start_i;
      l_q    <= length_i;
    end
    qc_q <= qc_d;
    qs_q <= qs_d;
  end

  assign used_a_o    = used_a_q;
  assign used_b_o    = used_b_q;
  assign q_valid_o   = qv_q;
  assign q_compute_o = qc_q;
  assign q_status_o  = qs_q;
endmodule

>>> hdl/rlbs_back.sv
// Back end: walks the run lists for the chosen operation and emits coalesced runs.
module rlbs_back #(
  parameter int unsigned MAX_RUNS  = 16,
  parameter int unsigned POS_WIDTH = 32,
  localparam int unsigned IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1,
  localparam int unsigned CW = $clog2(MAX_RUNS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  logic                 q_compute_i,
  input  logic [1:0]           q_status_i,
  output logic                 q_take_o,
  output logic                 busy_o,
  input  logic [1:0]           op_i,
  input  logic [31:0]          bitmap_size_i,
  input  logic [CW-1:0]        used_a_i,
  input  logic [CW-1:0]        used_b_i,
  output logic [IW-1:0]        rd_a_idx_o,
  output logic [IW-1:0]        rd_b_idx_o,
  input  logic [POS_WIDTH-1:0] a_start_i,
  input  logic [POS_WIDTH-1:0] a_length_i,
  input  logic [POS_WIDTH-1:0] b_start_i,
  input  logic [POS_WIDTH-1:0] b_length_i,
  output logic                 out_valid_o,
  output logic [31:0]          out_start_o,
  output logic [31:0]          out_length_o,
  output logic                 out_last_o,
  output logic [1:0]           out_status_o
);
  import rlbs_pkg::*;

  localparam int unsigned EW = POS_WIDTH + 1;

  back_state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [EW-1:0] cur_q, cur_d;
  logic          hv_q, hv_d;
  logic [EW-1:0] hs_q, hs_d, he_q, he_d;
  logic          ov_q, ov_d, ol_q, ol_d;
  logic [31:0]   os_q, os_d, oln_q, oln_d;
  logic [1:0]    ost_q, ost_d;
  logic          have_a, have_b, take_a, push, done;
  logic [EW-1:0] as, ae, bs, be, ps, pe, sz, nx;
  logic [EW-1:0] lenw;

  assign busy_o = (state_q != BK_IDLE);
  assign have_a = i_q < used_a_i;
  assign have_b = j_q < used_b_i;
  assign as = {1'b0, a_start_i};
  assign ae = as + {1'b0, a_length_i} - 1'b1;
  assign bs = {1'b0, b_start_i};
  assign be = bs + {1'b0, b_length_i} - 1'b1;
  assign nx = as + {1'b0, a_length_i};
  assign sz = EW'(bitmap_size_i);
  assign rd_a_idx_o = i_d[IW-1:0];
  assign rd_b_idx_o = j_d[IW-1:0];
  assign take_a = !have_b || (have_a && as <= bs);

  // candidate run for this step
  always_comb begin
    push = 1'b0;
    ps   = '0;
    pe   = '0;
    done = 1'b0;
    unique case (op_e'(op_i))
      OP_UNION: begin
        done = !have_a && !have_b;
        push = !done;
        ps   = take_a ? as : bs;
        pe   = take_a ? ae : be;
      end
      OP_INTER: begin
        done = !have_a || !have_b;
        ps   = (as > bs) ? as : bs;
        pe   = (ae < be) ? ae : be;
        push = !done && ps <= pe;
      end
      OP_COMPL: begin
        done = !have_a;
        push = !done && as > cur_q && cur_q < sz;
        ps   = cur_q;
        pe   = ((as < sz) ? as : sz) - 1'b1;
      end
      default: done = 1'b1;
    endcase
  end

  assign lenw = he_q - hs_q + 1'b1;

  always_comb begin
    state_d = state_q;
    i_d = i_q;  j_d = j_q;  cur_d = cur_q;
    hv_d = hv_q; hs_d = hs_q; he_d = he_q;
    q_take_o = 1'b0;
    ov_d = 1'b0; ol_d = 1'b0; os_d = os_q; oln_d = oln_q; ost_d = ST_OK;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_take_o = 1'b1;
          if (q_compute_i) begin
            state_d = BK_READ;
            i_d = '0; j_d = '0; cur_d = '0; hv_d = 1'b0;
          end else begin
            ov_d = 1'b1; ol_d = 1'b1; os_d = '0; oln_d = '0; ost_d = q_status_i;
          end
        end
      end
      BK_READ: state_d = BK_STEP;
      BK_STEP: begin
        if (done) begin
          state_d = BK_TAIL;
        end else begin
          state_d = BK_READ;
          unique case (op_e'(op_i))
            OP_UNION: if (take_a) i_d = i_q + 1'b1; else j_d = j_q + 1'b1;
            OP_INTER: if (ae <= be) i_d = i_q + 1'b1; else j_d = j_q + 1'b1;
            default: begin
              i_d = i_q + 1'b1;
              if (nx > cur_q) cur_d = nx;
            end
          endcase
          if (push) begin
            if (hv_q && ps <= he_q + 1'b1) begin
              if (pe > he_q) he_d = pe;
            end else begin
              if (hv_q) begin
                ov_d = 1'b1; os_d = 32'(hs_q); oln_d = 32'(lenw);
              end
              hv_d = 1'b1; hs_d = ps; he_d = pe;
            end
          end
        end
      end
      BK_TAIL: begin
        state_d = BK_FLUSH;
        if (op_e'(op_i) == OP_COMPL && cur_q < sz) begin
          if (hv_q && cur_q <= he_q + 1'b1) begin
            if (sz - 1'b1 > he_q) he_d = sz - 1'b1;
          end else begin
            if (hv_q) begin
              ov_d = 1'b1; os_d = 32'(hs_q); oln_d = 32'(lenw);
            end
            hv_d = 1'b1; hs_d = cur_q; he_d = sz - 1'b1;
          end
        end
      end
      BK_FLUSH: begin
        state_d = BK_IDLE;
        ov_d = 1'b1; ol_d = 1'b1;
        os_d  = hv_q ? 32'(hs_q) : '0;
        oln_d = hv_q ? 32'(lenw) : '0;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
      hv_q    <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      hv_q    <= hv_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; hs_q <= hs_d; he_q <= he_d;
    ol_q <= ol_d; os_q <= os_d; oln_q <= oln_d; ost_q <= ost_d;
  end

  assign out_valid_o  = ov_q;
  assign out_start_o  = os_q;
  assign out_length_o = oln_q;
  assign out_last_o   = ol_q;
  assign out_status_o = ost_q;
endmodule

>>> hdl/run_list_bitmap_set_ops_core.sv
// Top level of the run-list bitmap set-operation block: lists, registers, front and back.
//
//  channel  | signals                                       | transfer
//  ---------+-----------------------------------------------+------------------------------
//  command  | start, busy, func_i, run_start_i, run_length_i| start & ~busy
//  result   | out_strobe_o, out_start_o, out_length_o, ...  | out_strobe_o (one cycle)
//  config   | psel, penable, pwrite, paddr, pwdata          | psel&penable&pwrite&pready
//
// A load or clear result passes the pending flag, the queue entry and the output register;
// the next command can be accepted at the edge where that result transfers.
// A compute alternates a list read and a merge step for each stored run it visits,
// then takes a tail and a flush step; the flush gives the final result.
// busy also covers the whole list walk, so loads never change a list mid-walk.
// Reset empties both lists; contents stay. Results cannot be stalled.
module run_list_bitmap_set_ops_core #(
  parameter int unsigned MAX_RUNS  = 16,
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] run_start_i,
  input  logic [31:0] run_length_i,
  output logic        out_strobe_o,
  output logic [31:0] out_start_o,
  output logic [31:0] out_length_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rlbs_pkg::*;

  localparam int unsigned IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned CW = $clog2(MAX_RUNS + 1);

  logic [31:0] bitmap_size_q;
  logic [1:0]  set_op_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_size_q <= 32'hFFFF_FFFF;
      set_op_q      <= OP_UNION;
    end else if (cfg_wr) begin
      if (paddr[2] == 1'(CFG_BITMAP_SIZE)) bitmap_size_q <= pwdata;
      if (paddr[2] == 1'(CFG_SET_OP))      set_op_q      <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'(CFG_BITMAP_SIZE)) prdata = bitmap_size_q;
    else                                 prdata = {30'd0, set_op_q};
  end

  // run list storage
  logic [POS_WIDTH-1:0] a_st [MAX_RUNS];
  logic [POS_WIDTH-1:0] a_ln [MAX_RUNS];
  logic [POS_WIDTH-1:0] b_st [MAX_RUNS];
  logic [POS_WIDTH-1:0] b_ln [MAX_RUNS];

  logic                 wr_en, wr_b, back_busy;
  logic [IW-1:0]        wr_idx, rd_a_idx, rd_b_idx;
  logic [POS_WIDTH-1:0] wr_s, wr_l;
  logic [CW-1:0]        used_a, used_b;
  logic [POS_WIDTH-1:0] lr_s_q, lr_l_q, ra_s_q, ra_l_q, rb_s_q, rb_l_q;
  logic                 qv, qc, qtake;
  logic [1:0]           qs;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (wr_b) begin
        b_st[wr_idx] <= wr_s; b_ln[wr_idx] <= wr_l;
      end else begin
        a_st[wr_idx] <= wr_s; a_ln[wr_idx] <= wr_l;
      end
    end
    // last entry of the list a load targets, registered ahead of the front-end check
    if (func_i == FUNC_LOAD_B) begin
      lr_s_q <= b_st[IW'(used_b - 1'b1)]; lr_l_q <= b_ln[IW'(used_b - 1'b1)];
    end else begin
      lr_s_q <= a_st[IW'(used_a - 1'b1)]; lr_l_q <= a_ln[IW'(used_a - 1'b1)];
    end
    ra_s_q <= a_st[rd_a_idx]; ra_l_q <= a_ln[rd_a_idx];
    rb_s_q <= b_st[rd_b_idx]; rb_l_q <= b_ln[rd_b_idx];
  end

  rlbs_front #(.MAX_RUNS(MAX_RUNS), .POS_WIDTH(POS_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (start & ~busy),
    .func_i,
    .start_i      (run_start_i[POS_WIDTH-1:0]),
    .length_i     (run_length_i[POS_WIDTH-1:0]),
    .bitmap_size_i(bitmap_size_q),
    .back_busy_i  (back_busy),
    .busy_o       (busy),
    .lr_start_i   (lr_s_q),
    .lr_length_i  (lr_l_q),
    .wr_en_o      (wr_en),
    .wr_b_o       (wr_b),
    .wr_idx_o     (wr_idx),
    .wr_start_o   (wr_s),
    .wr_length_o  (wr_l),
    .used_a_o     (used_a),
    .used_b_o     (used_b),
    .q_valid_o    (qv),
    .q_compute_o  (qc),
    .q_status_o   (qs),
    .q_take_i     (qtake)
  );

  rlbs_back #(.MAX_RUNS(MAX_RUNS), .POS_WIDTH(POS_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i    (qv),
    .q_compute_i  (qc),
    .q_status_i   (qs),
    .q_take_o     (qtake),
    .busy_o       (back_busy),
    .op_i         (set_op_q),
    .bitmap_size_i(bitmap_size_q),
    .used_a_i     (used_a),
    .used_b_i     (used_b),
    .rd_a_idx_o   (rd_a_idx),
    .rd_b_idx_o   (rd_b_idx),
    .a_start_i    (ra_s_q),
    .a_length_i   (ra_l_q),
    .b_start_i    (rb_s_q),
    .b_length_i   (rb_l_q),
    .out_valid_o  (out_strobe_o),
    .out_start_o,
    .out_length_o,
    .out_last_o   (last_o),
    .out_status_o (status_o)
  );

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_a <= CW'(MAX_RUNS) && used_b <= CW'(MAX_RUNS))
    else $error("run count past capacity");
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && status_o != ST_OK |-> last_o && out_length_o == '0)
    else $error("refusal not a single final status item");
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");
endmodule

>>> bench/rlbs_checker.sv
// Checker for the run-list set-operation block: predicts results and compares them.
module rlbs_checker
  import rlbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  func_i,
  input  logic [31:0] run_start_i,
  input  logic [31:0] run_length_i,
  input  logic        out_strobe_i,
  input  logic [31:0] out_start_i,
  input  logic [31:0] out_length_i,
  input  logic        last_i,
  input  logic [1:0]  status_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int NRUNS = 16;
  localparam int NOUT  = 2 * NRUNS;

  typedef struct {
    logic [31:0] start;
    logic [31:0] length;
    logic        last;
    status_e     status;
  } run_rec_t;

  run_rec_t runs_due[$];

  logic [63:0] size_q;
  op_e         op_q;
  logic [63:0] a_st[NRUNS], a_ln[NRUNS], b_st[NRUNS], b_ln[NRUNS];
  logic [63:0] used_a, used_b;
  logic [63:0] acc_s[NOUT], acc_e[NOUT];
  int          acc_n;

  assign pending_o = runs_due.size();

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    errors_o++;
  endtask

  function automatic void push_run(logic [63:0] s, logic [63:0] e);
    if (acc_n > 0 && s <= acc_e[acc_n-1] + 1) begin
      if (e > acc_e[acc_n-1]) acc_e[acc_n-1] = e;
      return;
    end
    if (acc_n < NOUT) begin
      acc_s[acc_n] = s;
      acc_e[acc_n] = e;
      acc_n++;
    end
  endfunction

  // Append one run to list A (to_b=0) or B, or merge it into the last run it touches; return the load status.
  function automatic status_e append_run(bit to_b, logic [63:0] s, logic [63:0] l);
    logic [63:0] n, pe;
    n = to_b ? used_b : used_a;
    if (l == 0) return ST_OK;
    if (s + l > size_q) return ST_BEYOND;
    if (n > 0) begin
      pe = to_b ? b_st[n-1] + b_ln[n-1] - 1 : a_st[n-1] + a_ln[n-1] - 1;
      if (s <= pe) return ST_ORDER;
      if (s == pe + 1) begin
        if (to_b) b_ln[n-1] += l;
        else a_ln[n-1] += l;
        return ST_OK;
      end
    end
    if (n >= NRUNS) return ST_FULL;
    if (to_b) begin
      b_st[n] = s; b_ln[n] = l; used_b = n + 1;
    end else begin
      a_st[n] = s; a_ln[n] = l; used_a = n + 1;
    end
    return ST_OK;
  endfunction

  function automatic void walk_lists();
    logic [63:0] i, j, s, l, ae, be, e, cur, nx, lim;
    i = 0; j = 0; cur = 0;
    acc_n = 0;
    case (op_q)
      OP_UNION: begin
        while (i < used_a || j < used_b) begin
          if (j >= used_b || (i < used_a && a_st[i] <= b_st[j])) begin
            s = a_st[i]; l = a_ln[i]; i++;
          end else begin
            s = b_st[j]; l = b_ln[j]; j++;
          end
          push_run(s, s + l - 1);
        end
      end
      OP_INTER: begin
        while (i < used_a && j < used_b) begin
          ae = a_st[i] + a_ln[i] - 1;
          be = b_st[j] + b_ln[j] - 1;
          s = (a_st[i] > b_st[j]) ? a_st[i] : b_st[j];
          e = (ae < be) ? ae : be;
          if (s <= e) push_run(s, e);
          if (ae <= be) i++;
          else j++;
        end
      end
      OP_COMPL: begin
        for (i = 0; i < used_a; i++) begin
          s = a_st[i];
          nx = s + a_ln[i];
          if (s > cur && cur < size_q) begin
            lim = (s < size_q) ? s : size_q;
            push_run(cur, lim - 1);
          end
          if (nx > cur) cur = nx;
        end
        if (cur < size_q) push_run(cur, size_q - 1);
      end
      default: ;
    endcase
  endfunction

  function automatic void predict(func_e f, logic [31:0] s, logic [31:0] l);
    run_rec_t r;
    r.start = '0; r.length = '0; r.last = 1'b1; r.status = ST_OK;
    case (f)
      FUNC_LOAD_A: r.status = append_run(1'b0, {32'd0, s}, {32'd0, l});
      FUNC_LOAD_B: r.status = append_run(1'b1, {32'd0, s}, {32'd0, l});
      FUNC_CLEAR: begin
        used_a = 0; used_b = 0;
      end
      default: begin
        walk_lists();
        if (acc_n > 0) begin
          for (int k = 0; k < acc_n; k++) begin
            r.start  = acc_s[k][31:0];
            r.length = 32'(acc_e[k] - acc_s[k] + 1);
            r.last   = (k == acc_n - 1);
            runs_due.push_back(r);
          end
          return;
        end
      end
    endcase
    runs_due.push_back(r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    run_rec_t w;
    if (!rst_ni) begin
      size_q = 64'hFFFF_FFFF;
      op_q   = OP_UNION;
      used_a = 0;
      used_b = 0;
      runs_due.delete();
    end else begin
      if (out_strobe_i) begin
        if (runs_due.size() == 0) begin
          report("unexpected result start", out_start_i, 32'd0);
        end else begin
          w = runs_due.pop_front();
          if (out_start_i !== w.start) report("out_start", out_start_i, w.start);
          if (out_length_i !== w.length) report("out_length", out_length_i, w.length);
          if (last_i !== w.last) report("last", 32'(last_i), 32'(w.last));
          if (status_i !== w.status) report("status", 32'(status_i), 32'(w.status));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == 3'(4 * CFG_BITMAP_SIZE)) size_q = {32'd0, pwdata_i};
        else if (paddr_i == 3'(4 * CFG_SET_OP)) op_q = op_e'(pwdata_i[1:0]);
      end
      if (start_i && !busy_i) predict(func_e'(func_i), run_start_i, run_length_i);
    end
  end

  initial errors_o = 0;

endmodule

>>> bench/tb_run_list_bitmap_set_ops_core.sv
// Testbench top for the run-list set-operation block: stimulus and verdict.
module tb_run_list_bitmap_set_ops_core;
  import rlbs_pkg::*;

  logic        clk_i, rst_ni;
  logic        start, busy;
  logic [1:0]  func_i;
  logic [31:0] run_start_i, run_length_i;
  logic        out_strobe_o, last_o;
  logic [31:0] out_start_o, out_length_o;
  logic [1:0]  status_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending;
  int          n_items;

  run_list_bitmap_set_ops_core u_top (
    .clk_i, .rst_ni, .start, .busy, .func_i, .run_start_i, .run_length_i,
    .out_strobe_o, .out_start_o, .out_length_o, .last_o, .status_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rlbs_checker u_chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .func_i, .run_start_i,
    .run_length_i, .out_strobe_i(out_strobe_o), .out_start_i(out_start_o),
    .out_length_i(out_length_o), .last_i(last_o), .status_i(status_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3000000;
    $display("run_list_bitmap_set_ops_core verification failed");
    $finish;
  end

  // Issue one command; return at the edge where the transfer happens.
  task automatic send(func_e f, logic [31:0] s, logic [31:0] l);
    int gap;
    gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    func_i       <= f;
    run_start_i  <= s;
    run_length_i <= l;
    // Check busy mid-cycle, where it is settled, then take the accepting edge.
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    n_items++;
  endtask

  // Hold off until every expected result has come and the block has settled.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(int unsigned idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] sz, op_e op);
    drain();
    reg_write(CFG_BITMAP_SIZE, sz);
    reg_write(CFG_SET_OP, 32'(op));
  endtask

  // Load a mostly ascending run list with random gaps; some runs touch,
  // some are out of order, some run past the size.
  task automatic load_list(func_e f, int count, logic [31:0] sz);
    logic [63:0] cur, s, l, span;
    int r;
    cur = 0;
    span = (sz == 32'hFFFF_FFFF) ? 64'h400_0000 : {32'd0, sz} / 8 + 1;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 11);
      if (r == 0 && cur > 0) s = $urandom_range(0, 32'(cur - 1));
      else if (r == 1) s = cur;
      else s = cur + 1 + $urandom_range(0, 32'(span));
      l = $urandom_range(1, 32'(span));
      if (r == 11) l = {32'd0, $urandom} | 64'h1;
      if (s > 64'hFFFF_FFFE) s = $urandom_range(0, 32'hFFFF_FFFE);
      if (s >= cur) cur = s + l;
      send(f, s[31:0], l[31:0]);
    end
  endtask

  initial begin
    logic [31:0] sz;
    n_items = 0;
    rst_ni = 1'b0;
    start = 1'b0; func_i = FUNC_CLEAR; run_start_i = '0; run_length_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: merge, order, range, extremes at the default full size.
    send(FUNC_CLEAR, 32'd0, 32'd1);
    send(FUNC_LOAD_A, 32'd0, 32'd1);
    send(FUNC_LOAD_A, 32'd1, 32'd3);
    send(FUNC_LOAD_A, 32'd2, 32'd1);
    send(FUNC_LOAD_A, 32'hFFFF_FFFE, 32'd2);
    send(FUNC_LOAD_A, 32'hFFFF_FFFE, 32'd1);
    send(FUNC_LOAD_B, 32'd0, 32'hFFFF_FFFF);
    send(FUNC_COMPUTE, 32'd0, 32'd1);
    configure(32'hFFFF_FFFF, OP_INTER);
    send(FUNC_COMPUTE, 32'd0, 32'd1);
    configure(32'hFFFF_FFFF, OP_COMPL);
    send(FUNC_COMPUTE, 32'd0, 32'd1);
    configure(32'hFFFF_FFFF, OP_NONE);
    send(FUNC_COMPUTE, 32'd0, 32'd1);

    // Directed: fill A to full, merge into a full list, then a refused new run.
    configure(32'd64, OP_COMPL);
    send(FUNC_CLEAR, 32'd0, 32'd1);
    for (int k = 0; k < 16; k++) send(FUNC_LOAD_A, 32'(2 * k), 32'd1);
    send(FUNC_LOAD_A, 32'd31, 32'd2);
    send(FUNC_LOAD_A, 32'd40, 32'd1);
    send(FUNC_COMPUTE, 32'd0, 32'd1);
    // Shrink the size below some stored runs, then the smallest size.
    configure(32'd9, OP_COMPL);
    send(FUNC_COMPUTE, 32'd0, 32'd1);
    configure(32'd1, OP_UNION);
    send(FUNC_LOAD_B, 32'd0, 32'd1);
    send(FUNC_COMPUTE, 32'd0, 32'd1);

    // Random phases: configure, clear, load both lists, compute.
    while (n_items < 340) begin
      case ($urandom_range(0, 5))
        0: sz = 32'hFFFF_FFFF;
        1: sz = $urandom_range(1, 8);
        2: sz = $urandom;
        default: sz = $urandom_range(16, 300);
      endcase
      configure(sz, op_e'($urandom_range(0, 3)));
      send(FUNC_CLEAR, $urandom, $urandom);
      load_list(FUNC_LOAD_A, $urandom_range(0, 18), sz);
      load_list(FUNC_LOAD_B, $urandom_range(0, 18), sz);
      send(FUNC_COMPUTE, $urandom, $urandom);
      if (($urandom & 3) == 0)
        send(func_e'($urandom_range(0, 3)), $urandom, $urandom | 32'd1);
      if (($urandom & 1) == 0) send(FUNC_COMPUTE, $urandom, $urandom);
    end

    drain();
    if (errors == 0) begin
      $display("run_list_bitmap_set_ops_core verification clean");
    end else begin
      $display("run_list_bitmap_set_ops_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/rlbs_pkg.sv
hdl/rlbs_front.sv
hdl/rlbs_back.sv
hdl/run_list_bitmap_set_ops_core.sv
bench/rlbs_checker.sv
bench/tb_run_list_bitmap_set_ops_core.sv
